FILE: design/s2a_pkg.sv
`default_nettype none

package s2a_pkg;

   localparam int unsigned MagWidth   = 32;
   localparam int unsigned NumDigits  = 10;
   localparam int unsigned QueueDepth = 2;

   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharMinus = 8'h2D;

   // classified request handed from front to back
   typedef struct packed {
      logic                negative;
      logic [MagWidth-1:0] magnitude;
   } item_type;

   // one side of an internal valid/stall hop
   typedef struct packed {
      logic     valid;
      item_type item;
   } link_type;

endpackage

`default_nettype wire

FILE: design/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text.
// Request channel (req_valid / req_stall / req_number): one two's complement
// integer per request, taken at a clock edge with req_valid high and
// req_stall low.
// Response channel (rsp_valid / rsp_stall / rsp_out_char / rsp_last): one
// character per response: '-' for negative values, then the digits most
// significant first with leading zeros dropped; zero gives "0". rsp_last
// marks the final character. -2147483648 gives "-2147483648".
// Timing: a request is registered and classified in the front stage, waits
// in a two-entry queue, then the back end takes it, runs the shift-and-add-3
// conversion over all 32 magnitude bits, locates the leading digit, and
// emits the characters (1 to 11) through the output register. The back end
// takes the next number only after issuing the last character of the
// previous one.
// Later requests queue up while a number is in conversion.
// Reset (synchronous, active high) empties the queue and output register.
// A stalled response holds; the back end waits, and once the queue and the
// front stage are both full req_stall rises.
`default_nettype none

module signed_int_to_decimal_ascii (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [31:0]  req_number,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_last
);

   s2a_pkg::link_type  push;      // front stage into queue
   logic               push_stall;
   s2a_pkg::link_type  pop;       // queue head to back end
   logic               pop_take;

   // front: register the request, split into sign and magnitude
   s2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_number (req_number),
      .push       (push),
      .push_stall (push_stall)
   );

   // decouples intake from the slow conversion
   s2a_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_stall (push_stall),
      .pop        (pop),
      .pop_take   (pop_take)
   );

   // back: binary to BCD, then character emit through the output register
   s2a_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop          (pop),
      .pop_take     (pop_take),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_char (rsp_out_char),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

FILE: design/s2a_front.sv
`default_nettype none

module s2a_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [31:0]               req_number,
   output s2a_pkg::link_type              push,
   input  wire logic                      push_stall
);

   logic                 stage_valid_ff, stage_valid_in;
   s2a_pkg::item_type    stage_item_ff, stage_item_in;
   logic                 accept;

   assign req_stall = stage_valid_ff & push_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff & push_stall;
      stage_item_in  = stage_item_ff;
      if (accept) begin
         stage_valid_in          = 1'b1;
         stage_item_in.negative  = req_number[31];
         // two's complement negate; the most negative value maps to 2^31 unsigned
         stage_item_in.magnitude = req_number[31] ? (32'd0 - req_number) : req_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_item_ff <= stage_item_in;
   end

   assign push.valid = stage_valid_ff;
   assign push.item  = stage_item_ff;

endmodule

`default_nettype wire

FILE: design/s2a_queue.sv
`default_nettype none

module s2a_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire s2a_pkg::link_type    push,
   output logic                      push_stall,
   output s2a_pkg::link_type         pop,
   input  wire logic                 pop_take
);

   localparam int unsigned PtrWidth = (s2a_pkg::QueueDepth > 1) ?
                                      $clog2(s2a_pkg::QueueDepth) : 1;
   localparam int unsigned CntWidth = $clog2(s2a_pkg::QueueDepth + 1);

   s2a_pkg::item_type     slot_ff [s2a_pkg::QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_stall = (count_ff == CntWidth'(s2a_pkg::QueueDepth));
   assign do_push    = push.valid & ~push_stall;
   assign do_pop     = pop_take & (count_ff != '0);

   assign pop.valid = (count_ff != '0);
   assign pop.item  = slot_ff[rd_ptr_ff];

   function automatic logic [PtrWidth-1:0] bump(input logic [PtrWidth-1:0] p);
      if (p == PtrWidth'(s2a_pkg::QueueDepth - 1)) begin
         bump = '0;
      end else begin
         bump = p + 1'b1;
      end
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

FILE: design/s2a_back.sv
`default_nettype none

module s2a_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire s2a_pkg::link_type    pop,
   output logic                      pop_take,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_out_char,
   output logic                      rsp_last
);

   localparam int unsigned DigW   = $clog2(s2a_pkg::NumDigits);
   localparam int unsigned CntW   = $clog2(s2a_pkg::MagWidth);
   localparam int unsigned BcdW   = 4 * s2a_pkg::NumDigits;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_FIND,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   typedef logic [s2a_pkg::NumDigits-1:0][3:0] bcd_type;

   state_type                     state_ff, state_in;
   logic [s2a_pkg::MagWidth-1:0]  bin_ff, bin_in;
   bcd_type                       bcd_ff, bcd_in;
   logic [CntW-1:0]               cnt_ff, cnt_in;
   logic [DigW-1:0]               pos_ff, pos_in;
   logic                          neg_ff, neg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [7:0]                    rsp_char_ff, rsp_char_in;
   logic                          rsp_last_ff, rsp_last_in;
   bcd_type                       adj;
   logic [BcdW-1:0]               adj_flat;
   logic                          out_free;

   // index of the most significant nonzero digit, zero when all digits are zero
   function automatic logic [DigW-1:0] lead_pos(input bcd_type b);
      lead_pos = '0;
      for (int i = 0; i < int'(s2a_pkg::NumDigits); i++) begin
         if (b[i] != 4'd0) begin
            lead_pos = DigW'(i);
         end
      end
   endfunction

   // add-3 correction ahead of each shift
   always_comb begin
      for (int i = 0; i < int'(s2a_pkg::NumDigits); i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? (bcd_ff[i] + 4'd3) : bcd_ff[i];
      end
      adj_flat = adj;
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      pop_take     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pop.valid) begin
               pop_take = 1'b1;
               bin_in   = pop.item.magnitude;
               neg_in   = pop.item.negative;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {adj_flat[BcdW-2:0], bin_ff[s2a_pkg::MagWidth-1]};
            bin_in = {bin_ff[s2a_pkg::MagWidth-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(s2a_pkg::MagWidth - 1)) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            pos_in   = lead_pos(bcd_ff);
            state_in = neg_ff ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = s2a_pkg::CharMinus;
               rsp_last_in  = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = s2a_pkg::CharZero + {4'd0, bcd_ff[pos_ff]};
               rsp_last_in  = (pos_ff == '0);
               if (pos_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire
